>>> rtl/dsuv_pkg.sv
// ----------------------------------------------------------------------------
// dsuv_pkg
// Shared constants and the arctangent step table for the direction to sphere
// UV mapping block.
// ----------------------------------------------------------------------------
package dsuv_pkg;

    localparam int ANGLE_FRAC = 32;
    localparam int ACC_W      = 34;
    localparam int TABLE_LEN  = 24;

    localparam logic signed [ACC_W-1:0] QUARTER_TURN = ACC_W'(1) << (ANGLE_FRAC - 2);
    localparam logic [ANGLE_FRAC-1:0]   HALF_TURN    = ANGLE_FRAC'(1) << (ANGLE_FRAC - 1);

    // round(atan(2^-i) / (2*pi) * 2^32)
    function automatic logic [ANGLE_FRAC-1:0] stage_angle(input int idx);
        logic [ANGLE_FRAC-1:0] a;
        case (idx)
            0:       a = 32'd536870912;
            1:       a = 32'd316933406;
            2:       a = 32'd167458907;
            3:       a = 32'd85004756;
            4:       a = 32'd42667331;
            5:       a = 32'd21354465;
            6:       a = 32'd10679838;
            7:       a = 32'd5340245;
            8:       a = 32'd2670163;
            9:       a = 32'd1335087;
            10:      a = 32'd667544;
            11:      a = 32'd333772;
            12:      a = 32'd166886;
            13:      a = 32'd83443;
            14:      a = 32'd41722;
            15:      a = 32'd20861;
            16:      a = 32'd10430;
            17:      a = 32'd5215;
            18:      a = 32'd2608;
            19:      a = 32'd1304;
            20:      a = 32'd652;
            21:      a = 32'd326;
            22:      a = 32'd163;
            23:      a = 32'd81;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

>>> rtl/direction_to_sphere_uv.sv
// ----------------------------------------------------------------------------
// direction_to_sphere_uv
// Equirectangular texture coordinates for the direction from a vertex toward
// the origin, computed by a square-root chain and two CORDIC chains.
// ----------------------------------------------------------------------------
// Takes one vertex per cycle while s_axis_tready is high and returns one
// (tex_u, tex_v, zero_vector) beat per vertex, in order. The chain has three
// front stages (negate and scale, square, sum), NSQ square root cells, where
// NSQ is 31 for COORD_WIDTH below 31 and COORD_WIDTH otherwise, ANGLE_STAGES
// CORDIC cells for v, then the output register. The u CORDIC runs beside the
// square root. The whole chain advances together; a skid register behind the
// output register holds one more beat, and s_axis_tready drops only while
// that skid register is full.
module direction_to_sphere_uv
    import dsuv_pkg::*;
#(
    parameter int COORD_WIDTH  = 16,
    parameter int UV_WIDTH     = 16,
    parameter int ANGLE_STAGES = 16
)(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // pos_x, pos_y, pos_z
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // tex_u, tex_v
    output logic [((2*UV_WIDTH+7)/8)*8-1:0]       m_axis_tdata,
    // zero_vector
    output logic [0:0]                            m_axis_tuser
);

    localparam int GUARD  = (COORD_WIDTH < 31) ? (31 - COORD_WIDTH) : 0;
    localparam int SW     = COORD_WIDTH + GUARD;
    localparam int CORD_W = SW + 3;
    localparam int SUM_W  = 2 * SW;
    localparam int NSQ    = SW;
    localparam int DLY    = NSQ + 1;
    localparam int DROP   = ANGLE_FRAC - UV_WIDTH;
    localparam int OUT_W  = ((2*UV_WIDTH+7)/8)*8;
    localparam logic [ANGLE_FRAC-1:0] HALF_LSB = ANGLE_FRAC'(1) << (DROP - 1);

    logic en;

    // ---------------- stage a: negate and scale
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;
    logic signed [COORD_WIDTH:0]   neg_x;
    logic signed [COORD_WIDTH:0]   neg_y;
    logic signed [COORD_WIDTH:0]   neg_z;
    logic signed [SW:0]            a_sx_next;
    logic signed [SW:0]            a_sy_next;
    logic signed [SW:0]            a_sz_next;

    logic              a_valid_reg;
    logic signed [SW:0] a_sx_reg;
    logic signed [SW:0] a_sy_reg;
    logic signed [SW:0] a_sz_reg;
    logic              a_zero_reg;
    logic              a_pole_reg;

    assign pos_x = s_axis_tdata[COORD_WIDTH-1:0];
    assign pos_y = s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
    assign pos_z = s_axis_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];

    assign neg_x = -((COORD_WIDTH + 1)'(pos_x));
    assign neg_y = -((COORD_WIDTH + 1)'(pos_y));
    assign neg_z = -((COORD_WIDTH + 1)'(pos_z));

    assign a_sx_next = ((SW + 1)'(neg_x)) <<< GUARD;
    assign a_sy_next = ((SW + 1)'(neg_y)) <<< GUARD;
    assign a_sz_next = ((SW + 1)'(neg_z)) <<< GUARD;

    // ---------------- stage b: squares and u prerotation
    logic signed [2*SW+1:0]    sq_x;
    logic signed [2*SW+1:0]    sq_z;
    logic signed [CORD_W-1:0]  ux;
    logic signed [CORD_W-1:0]  uy;
    logic signed [CORD_W-1:0]  b_ux_next;
    logic signed [CORD_W-1:0]  b_uy_next;
    logic signed [ACC_W-1:0]   b_uacc_next;

    logic                      b_valid_reg;
    logic [SUM_W-1:0]          b_sx2_reg;
    logic [SUM_W-1:0]          b_sz2_reg;
    logic signed [SW:0]        b_sy_reg;
    logic                      b_zero_reg;
    logic                      b_pole_reg;
    logic signed [CORD_W-1:0]  b_ux_reg;
    logic signed [CORD_W-1:0]  b_uy_reg;
    logic signed [ACC_W-1:0]   b_uacc_reg;

    assign sq_x = a_sx_reg * a_sx_reg;
    assign sq_z = a_sz_reg * a_sz_reg;

    always_comb
    begin
        ux          = CORD_W'(a_sx_reg);
        uy          = CORD_W'(a_sz_reg);
        b_ux_next   = ux;
        b_uy_next   = uy;
        b_uacc_next = '0;
        if (ux[CORD_W-1])
        begin
            if (!uy[CORD_W-1])
            begin
                b_ux_next   = uy;
                b_uy_next   = -ux;
                b_uacc_next = QUARTER_TURN;
            end
            else
            begin
                b_ux_next   = -uy;
                b_uy_next   = ux;
                b_uacc_next = -QUARTER_TURN;
            end
        end
    end

    // ---------------- stage c: sum of squares
    logic               c_valid_reg;
    logic [SUM_W-1:0]   c_sum_reg;
    logic signed [SW:0] c_sy_reg;
    logic               c_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= s_axis_tvalid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_sx_reg   <= a_sx_next;
            a_sy_reg   <= a_sy_next;
            a_sz_reg   <= a_sz_next;
            a_zero_reg <= (pos_x == '0) && (pos_y == '0) && (pos_z == '0);
            a_pole_reg <= (pos_x == '0) && (pos_z == '0);

            b_sx2_reg  <= sq_x[SUM_W-1:0];
            b_sz2_reg  <= sq_z[SUM_W-1:0];
            b_sy_reg   <= a_sy_reg;
            b_zero_reg <= a_zero_reg;
            b_pole_reg <= a_pole_reg;
            b_ux_reg   <= b_ux_next;
            b_uy_reg   <= b_uy_next;
            b_uacc_reg <= b_uacc_next;

            c_sum_reg  <= b_sx2_reg + b_sz2_reg;
            c_sy_reg   <= b_sy_reg;
            c_zero_reg <= b_zero_reg;
        end
    end

    // ---------------- square root chain
    logic              sq_valid [NSQ+1];
    logic [SUM_W-1:0]  sq_rem   [NSQ+1];
    logic [SUM_W-1:0]  sq_root  [NSQ+1];
    logic [SW+1:0]     sq_side  [NSQ+1];

    assign sq_valid[0] = c_valid_reg;
    assign sq_rem[0]   = c_sum_reg;
    assign sq_root[0]  = '0;
    assign sq_side[0]  = {c_sy_reg, c_zero_reg};

    for (genvar k = 0; k < NSQ; k++)
    begin : g_sqrt
        dsuv_sqrt_cell #(
            .SUM_W   (SUM_W),
            .BIT_POS (2 * (NSQ - 1 - k)),
            .SIDE_W  (SW + 2)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (sq_valid[k]),
            .in_rem    (sq_rem[k]),
            .in_root   (sq_root[k]),
            .in_side   (sq_side[k]),
            .out_valid (sq_valid[k+1]),
            .out_rem   (sq_rem[k+1]),
            .out_root  (sq_root[k+1]),
            .out_side  (sq_side[k+1])
        );
    end

    // ---------------- u CORDIC chain
    logic                     u_valid [ANGLE_STAGES+1];
    logic signed [CORD_W-1:0] u_x     [ANGLE_STAGES+1];
    logic signed [CORD_W-1:0] u_y     [ANGLE_STAGES+1];
    logic signed [ACC_W-1:0]  u_acc   [ANGLE_STAGES+1];
    logic [0:0]               u_side  [ANGLE_STAGES+1];

    assign u_valid[0] = b_valid_reg;
    assign u_x[0]     = b_ux_reg;
    assign u_y[0]     = b_uy_reg;
    assign u_acc[0]   = b_uacc_reg;
    assign u_side[0]  = b_pole_reg;

    for (genvar i = 0; i < ANGLE_STAGES; i++)
    begin : g_ucordic
        dsuv_cordic_cell #(
            .CORD_W (CORD_W),
            .STAGE  (i),
            .SIDE_W (1)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (u_valid[i]),
            .in_x      (u_x[i]),
            .in_y      (u_y[i]),
            .in_acc    (u_acc[i]),
            .in_side   (u_side[i]),
            .out_valid (u_valid[i+1]),
            .out_x     (u_x[i+1]),
            .out_y     (u_y[i+1]),
            .out_acc   (u_acc[i+1]),
            .out_side  (u_side[i+1])
        );
    end

    // hold the u angle until the v angle catches up
    logic signed [ACC_W-1:0] dl_acc_reg  [DLY];
    logic                    dl_pole_reg [DLY];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dl_acc_reg[0]  <= u_acc[ANGLE_STAGES];
            dl_pole_reg[0] <= u_side[ANGLE_STAGES][0];
            for (int d = 1; d < DLY; d++)
            begin
                dl_acc_reg[d]  <= dl_acc_reg[d-1];
                dl_pole_reg[d] <= dl_pole_reg[d-1];
            end
        end
    end

    // ---------------- v CORDIC chain
    logic                     v_valid [ANGLE_STAGES+1];
    logic signed [CORD_W-1:0] v_x     [ANGLE_STAGES+1];
    logic signed [CORD_W-1:0] v_y     [ANGLE_STAGES+1];
    logic signed [ACC_W-1:0]  v_acc   [ANGLE_STAGES+1];
    logic [0:0]               v_side  [ANGLE_STAGES+1];
    logic signed [SW:0]       v_sy;

    assign v_sy       = sq_side[NSQ][SW+1:1];
    assign v_valid[0] = sq_valid[NSQ];
    assign v_x[0]     = CORD_W'(sq_root[NSQ][SW-1:0]);
    assign v_y[0]     = CORD_W'(v_sy);
    assign v_acc[0]   = '0;
    assign v_side[0]  = sq_side[NSQ][0];

    for (genvar j = 0; j < ANGLE_STAGES; j++)
    begin : g_vcordic
        dsuv_cordic_cell #(
            .CORD_W (CORD_W),
            .STAGE  (j),
            .SIDE_W (1)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (v_valid[j]),
            .in_x      (v_x[j]),
            .in_y      (v_y[j]),
            .in_acc    (v_acc[j]),
            .in_side   (v_side[j]),
            .out_valid (v_valid[j+1]),
            .out_x     (v_x[j+1]),
            .out_y     (v_y[j+1]),
            .out_acc   (v_acc[j+1]),
            .out_side  (v_side[j+1])
        );
    end

    // ---------------- angle to texture coordinate
    logic                      res_zero;
    logic                      res_pole;
    logic [ANGLE_FRAC-1:0]     u_sum;
    logic [UV_WIDTH-1:0]       res_u;
    logic signed [ACC_W+1:0]   v_tv;
    logic [ACC_W:0]            v_clip;
    logic [ACC_W+1:0]          v_rnd;
    logic [ACC_W+1-DROP:0]     v_top;
    logic                      v_sat;
    logic [UV_WIDTH-1:0]       res_v;
    logic                      emerge;

    assign res_zero = v_side[ANGLE_STAGES][0];
    assign res_pole = dl_pole_reg[DLY-1];

    always_comb
    begin
        u_sum  = dl_acc_reg[DLY-1][ANGLE_FRAC-1:0] + HALF_TURN + HALF_LSB;
        res_u  = (res_zero || res_pole) ? '0 : u_sum[ANGLE_FRAC-1:DROP];

        v_tv   = $signed({v_acc[ANGLE_STAGES], 1'b0})
               + $signed((ACC_W + 2)'(HALF_TURN));
        v_clip = v_tv[ACC_W+1] ? '0 : v_tv[ACC_W:0];
        v_rnd  = {1'b0, v_clip} + (ACC_W + 2)'(HALF_LSB);
        v_top  = v_rnd[ACC_W+1:DROP];
        v_sat  = |v_top[ACC_W+1-DROP:UV_WIDTH];
        if (res_zero)
            res_v = '0;
        else if (v_sat)
            res_v = '1;
        else
            res_v = v_top[UV_WIDTH-1:0];
    end

    // ---------------- output register and skid
    logic                      out_valid_reg;
    logic [2*UV_WIDTH-1:0]     out_data_reg;
    logic                      out_zero_reg;
    logic                      skid_valid_reg;
    logic [2*UV_WIDTH-1:0]     skid_data_reg;
    logic                      skid_zero_reg;
    logic                      out_free;

    assign en       = !skid_valid_reg;
    assign emerge   = en && v_valid[ANGLE_STAGES];
    assign out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || emerge;
            skid_valid_reg <= 1'b0;
        end
        else if (emerge)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
                out_zero_reg <= skid_zero_reg;
            end
            else
            begin
                out_data_reg <= {res_v, res_u};
                out_zero_reg <= res_zero;
            end
        end
        else if (emerge)
        begin
            skid_data_reg <= {res_v, res_u};
            skid_zero_reg <= res_zero;
        end
    end

    assign s_axis_tready = en;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'(out_data_reg);
    assign m_axis_tuser  = out_zero_reg;

    // ---------------- assertions
    a_skid_behind_output : assert property (
        @(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> m_axis_tvalid
    ) else $error("skid holds a beat while the output register is empty");

    a_skid_fill_on_stall : assert property (
        @(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !$past(skid_valid_reg)) |-> $past(m_axis_tvalid && !m_axis_tready)
    ) else $error("skid filled without an output stall");

    a_zero_gives_origin : assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[2*UV_WIDTH-1:0] == '0)
    ) else $error("zero vector beat carries nonzero coordinates");

endmodule

>>> rtl/dsuv_sqrt_cell.sv
// ----------------------------------------------------------------------------
// dsuv_sqrt_cell
// One digit of a pipelined restoring integer square root; carries a side band.
// ----------------------------------------------------------------------------
module dsuv_sqrt_cell #(
    parameter int SUM_W   = 62,
    parameter int BIT_POS = 60,
    parameter int SIDE_W  = 1
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [SUM_W-1:0]  in_rem,
    input  logic [SUM_W-1:0]  in_root,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [SUM_W-1:0]  out_rem,
    output logic [SUM_W-1:0]  out_root,
    output logic [SIDE_W-1:0] out_side
);

    localparam logic [SUM_W:0] ROOT_BIT = (SUM_W + 1)'(1) << BIT_POS;

    logic              valid_reg;
    logic [SUM_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  rem_next;
    logic [SUM_W-1:0]  root_reg;
    logic [SUM_W-1:0]  root_next;
    logic [SIDE_W-1:0] side_reg;
    logic [SUM_W:0]    trial;

    always_comb
    begin
        trial = {1'b0, in_root} + ROOT_BIT;
        if ({1'b0, in_rem} >= trial)
        begin
            rem_next  = SUM_W'({1'b0, in_rem} - trial);
            root_next = SUM_W'({2'b00, in_root[SUM_W-1:1]} + ROOT_BIT);
        end
        else
        begin
            rem_next  = in_rem;
            root_next = {1'b0, in_root[SUM_W-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_side  = side_reg;

endmodule

>>> rtl/dsuv_cordic_cell.sv
// ----------------------------------------------------------------------------
// dsuv_cordic_cell
// One vectoring CORDIC step: rotate toward the x axis and accumulate angle.
// ----------------------------------------------------------------------------
module dsuv_cordic_cell
    import dsuv_pkg::*;
#(
    parameter int CORD_W = 34,
    parameter int STAGE  = 0,
    parameter int SIDE_W = 1
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic signed [CORD_W-1:0] in_x,
    input  logic signed [CORD_W-1:0] in_y,
    input  logic signed [ACC_W-1:0]  in_acc,
    input  logic [SIDE_W-1:0]        in_side,
    output logic                     out_valid,
    output logic signed [CORD_W-1:0] out_x,
    output logic signed [CORD_W-1:0] out_y,
    output logic signed [ACC_W-1:0]  out_acc,
    output logic [SIDE_W-1:0]        out_side
);

    localparam logic signed [ACC_W-1:0] STEP = $signed(ACC_W'(stage_angle(STAGE)));

    logic                     valid_reg;
    logic signed [CORD_W-1:0] x_reg;
    logic signed [CORD_W-1:0] x_next;
    logic signed [CORD_W-1:0] y_reg;
    logic signed [CORD_W-1:0] y_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic [SIDE_W-1:0]        side_reg;
    logic signed [CORD_W-1:0] xs;
    logic signed [CORD_W-1:0] ys;

    always_comb
    begin
        xs = in_x >>> STAGE;
        ys = in_y >>> STAGE;
        if (!in_y[CORD_W-1])
        begin
            x_next   = in_x + ys;
            y_next   = in_y - xs;
            acc_next = in_acc + STEP;
        end
        else
        begin
            x_next   = in_x - ys;
            y_next   = in_y + xs;
            acc_next = in_acc - STEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            acc_reg  <= acc_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_acc   = acc_reg;
    assign out_side  = side_reg;

endmodule

>>> tb/sphere_uv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_uv_checker
// Watches both stream channels of direction_to_sphere_uv. Every vertex
// accepted on the input side is turned into the texture coordinates it should
// give, using an independent fixed-point CORDIC and integer square root. These
// are queued in order. Every beat accepted on the output side is compared,
// field by field, with the oldest queued entry. Mismatches and beats that
// arrive with nothing queued are counted and handed to the top level.
// ----------------------------------------------------------------------------
module sphere_uv_checker #(
    parameter int COORD_WIDTH  = 16,
    parameter int UV_WIDTH     = 16,
    parameter int ANGLE_STAGES = 16
)(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    input  logic                                  s_axis_tready,
    // pos_x, pos_y, pos_z
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    input  logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // tex_u, tex_v
    input  logic [((2*UV_WIDTH+7)/8)*8-1:0]       m_axis_tdata,
    // zero_vector
    input  logic [0:0]                            m_axis_tuser,
    output int                                    mismatches,
    output int                                    outstanding
);

    localparam int     GUARD      = (COORD_WIDTH < 31) ? (31 - COORD_WIDTH) : 0;
    localparam int     DROP       = 32 - UV_WIDTH;
    localparam longint HALF_TURNS = 64'sd1 <<< 31;
    localparam longint QTR_TURNS  = 64'sd1 <<< 30;
    localparam longint HALF_LSB   = 64'sd1 <<< (DROP - 1);
    localparam longint UV_TOP     = (64'sd1 <<< UV_WIDTH) - 1;

    // atan(2^-k) in units of 2^-32 turn
    localparam longint STEP_TURNS [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838,  5340245,   2670163,   1335087,  667544,   333772,
        166886,    83443,     41722,     20861,    10430,    5215,
        2608,      1304,      652,       326,      163,      81};

    typedef struct packed {
        logic [UV_WIDTH-1:0] tex_u;
        logic [UV_WIDTH-1:0] tex_v;
        logic                zero_vector;
    } uv_beat_t;

    uv_beat_t uv_expected [$];
    uv_beat_t got_beat;
    uv_beat_t want_beat;
    int       fail_count = 0;
    int       queued     = 0;

    assign mismatches  = fail_count;
    assign outstanding = queued;

    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned probe;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > n)
            probe >>= 2;
        while (probe != 0)
        begin
            if (n >= root + probe)
            begin
                n    -= root + probe;
                root  = (root >> 1) + probe;
            end
            else
            begin
                root >>= 1;
            end
            probe >>= 2;
        end
        return root;
    endfunction

    // Angle of (vx, vy) in units of 2^-32 turn
    function automatic longint cordic_turns(longint vx, longint vy);
        longint acc;
        longint tmp;
        longint xs;
        longint ys;
        int     k;
        acc = 0;
        if (vx < 0)
        begin
            tmp = vx;
            if (vy >= 0)
            begin
                vx  = vy;
                vy  = -tmp;
                acc = QTR_TURNS;
            end
            else
            begin
                vx  = -vy;
                vy  = tmp;
                acc = -QTR_TURNS;
            end
        end
        for (k = 0; k < ANGLE_STAGES && k < 24; k++)
        begin
            xs = vx >>> k;
            ys = vy >>> k;
            if (vy >= 0)
            begin
                vx  += ys;
                vy  -= xs;
                acc += STEP_TURNS[k];
            end
            else
            begin
                vx  -= ys;
                vy  += xs;
                acc -= STEP_TURNS[k];
            end
        end
        return acc;
    endfunction

    function automatic uv_beat_t sphere_uv_of(logic signed [COORD_WIDTH-1:0] px,
                                              logic signed [COORD_WIDTH-1:0] py,
                                              logic signed [COORD_WIDTH-1:0] pz);
        longint          dx;
        longint          dy;
        longint          dz;
        longint          sx;
        longint          sy;
        longint          sz;
        longint          av;
        longint          tv;
        longint          vq;
        longint unsigned horiz;
        logic [63:0]     uacc;
        uv_beat_t        r;
        dx = -longint'(px);
        dy = -longint'(py);
        dz = -longint'(pz);
        r  = '0;
        if (dx == 0 && dy == 0 && dz == 0)
        begin
            r.zero_vector = 1'b1;
            return r;
        end
        sx = dx <<< GUARD;
        sy = dy <<< GUARD;
        sz = dz <<< GUARD;
        if (dx != 0 || dz != 0)
        begin
            uacc    = cordic_turns(sx, sz) + HALF_TURNS + HALF_LSB + 4 * HALF_TURNS;
            r.tex_u = uacc[DROP +: UV_WIDTH];
        end
        horiz = floor_sqrt(longint'(sx * sx) + longint'(sz * sz));
        av    = cordic_turns(longint'(horiz), sy);
        tv    = HALF_TURNS + 2 * av;
        if (tv < 0)
            tv = 0;
        vq = (tv + HALF_LSB) >>> DROP;
        if (vq > UV_TOP)
            vq = UV_TOP;
        r.tex_v = vq[UV_WIDTH-1:0];
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_beat.tex_u       = m_axis_tdata[0 +: UV_WIDTH];
                got_beat.tex_v       = m_axis_tdata[UV_WIDTH +: UV_WIDTH];
                got_beat.zero_vector = m_axis_tuser[0];
                if (uv_expected.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: unexpected beat u=%h v=%h zero=%b", $realtime,
                                 got_beat.tex_u, got_beat.tex_v, got_beat.zero_vector);
                    fail_count++;
                end
                else
                begin
                    want_beat = uv_expected.pop_front();
                    if (got_beat !== want_beat)
                    begin
                        if (fail_count < 10)
                            $display("%0t: mismatch exp u=%h v=%h zero=%b got u=%h v=%h zero=%b",
                                     $realtime, want_beat.tex_u, want_beat.tex_v,
                                     want_beat.zero_vector, got_beat.tex_u, got_beat.tex_v,
                                     got_beat.zero_vector);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                uv_expected.insert(uv_expected.size(),
                                   sphere_uv_of(s_axis_tdata[0 +: COORD_WIDTH],
                                                s_axis_tdata[COORD_WIDTH +: COORD_WIDTH],
                                                s_axis_tdata[2*COORD_WIDTH +: COORD_WIDTH]));
            queued = uv_expected.size();
        end
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives vertex positions into direction_to_sphere_uv and gives the verdict.
// A directed set covers the zero vector, both poles, the axes, the most
// negative and most positive coordinates and the seam where u wraps; random
// vertices of mixed magnitude follow under four idle/stall patterns. Checking
// is done by sphere_uv_checker beside the block.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CW             = 16;
    localparam int UV             = 16;
    localparam int STAGES         = 16;
    localparam int IN_W           = ((3*CW+7)/8)*8;
    localparam int OUT_W          = ((2*UV+7)/8)*8;
    localparam int LATENCY        = 31 + STAGES + 4;
    localparam int RANDOM_PER_PHASE = 257;
    localparam int QUIET_LIMIT    = 5000;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic [0:0]        m_axis_tuser;
    int                mismatches;
    int                outstanding;
    int                src_idle_pct  = 0;
    int                sink_stall_pct = 0;
    int                quiet_cycles  = 0;

    direction_to_sphere_uv #(
        .COORD_WIDTH  (CW),
        .UV_WIDTH     (UV),
        .ANGLE_STAGES (STAGES)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    sphere_uv_checker #(
        .COORD_WIDTH  (CW),
        .UV_WIDTH     (UV),
        .ANGLE_STAGES (STAGES)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("direction_to_sphere_uv test failed");
                $finish;
            end
        end
    end

    function automatic logic signed [CW-1:0] rand_coord();
        logic signed [CW-1:0] c;
        case ($urandom_range(9))
            0:       c = '0;
            1:
            begin
                case ($urandom_range(3))
                    0:       c = {1'b1, {(CW-1){1'b0}}};
                    1:       c = {1'b0, {(CW-1){1'b1}}};
                    2:       c = '1;
                    default: c = CW'(1);
                endcase
            end
            2, 3, 4: c = CW'($urandom);
            default: c = $signed(CW'($urandom)) >>> $urandom_range(CW-1, 0);
        endcase
        return c;
    endfunction

    // enter and leave at a falling edge
    task automatic send_vertex(input logic signed [CW-1:0] px,
                               input logic signed [CW-1:0] py,
                               input logic signed [CW-1:0] pz);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'({pz, py, px});
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic send_point(input int px, input int py, input int pz);
        send_vertex(CW'(px), CW'(py), CW'(pz));
    endtask

    task automatic send_random_vertex();
        int shape;
        shape = $urandom_range(99);
        if (shape < 2)
            send_vertex('0, '0, '0);
        else if (shape < 6)
            send_vertex('0, rand_coord(), '0);
        else if (shape < 10)
            send_vertex(rand_coord(), rand_coord(), '0);
        else if (shape < 14)
            send_vertex('0, rand_coord(), rand_coord());
        else
            send_vertex(rand_coord(), rand_coord(), rand_coord());
    endtask

    initial
    begin
        int phase;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_point(0, 0, 0);
        send_point(0, 1, 0);
        send_point(0, -1, 0);
        send_point(0, 32767, 0);
        send_point(0, -32768, 0);
        send_point(1, 0, 0);
        send_point(-1, 0, 0);
        send_point(0, 0, 1);
        send_point(0, 0, -1);
        send_point(32767, 0, 0);
        send_point(-32768, 0, 0);
        send_point(0, 0, 32767);
        send_point(0, 0, -32768);
        send_point(1, 0, 1);
        send_point(1, 0, -1);
        send_point(32767, 0, -1);
        send_point(1, -32768, 0);
        send_point(-1, 32767, 0);
        send_point(-32768, -32768, -32768);
        send_point(32767, 32767, 32767);
        send_point(-32768, 32767, -32768);
        send_point(32767, -32768, 32767);
        send_point(12345, -2345, -30000);
        send_point(-1, -1, -1);
        send_point(1, 1, 1);

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct   = 53;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 53;
                end
                default:
                begin
                    src_idle_pct   = 25;
                    sink_stall_pct = 25;
                end
            endcase
            repeat (RANDOM_PER_PHASE) send_random_vertex();
        end
        s_axis_tvalid <= 1'b0;

        while (outstanding != 0)
            @(negedge clk);
        repeat (2 * LATENCY) @(negedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("direction_to_sphere_uv test passed");
        else
            $display("direction_to_sphere_uv test failed");
        $finish;
    end

endmodule
